// ----- src/led_grayscale_packer_shifter_core_defines.svh -----
// Assertion macros shared by the grayscale packer design.
`ifndef LED_GRAYSCALE_PACKER_SHIFTER_CORE_DEFINES_SVH
`define LED_GRAYSCALE_PACKER_SHIFTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LGPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lgps: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define LGPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lgps: next-cycle check failed");

`endif

// ----- src/lgps_pkg.sv -----
`default_nettype none
package lgps_pkg;

  localparam int CHANNELS     = 16;
  localparam int LEVEL_W      = 12;
  localparam int CMD_W        = 2;
  localparam int IDX_W        = 4;
  localparam int BYTE_W       = 8;
  localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STREAM_BITS  = CHANNELS * LEVEL_W;
  localparam int STREAM_BYTES = (STREAM_BITS + BYTE_W - 1) / BYTE_W;
  localparam int STREAM_W     = STREAM_BYTES * BYTE_W;
  localparam int CNT_W        = $clog2(STREAM_BYTES);
  // Wide enough for group base plus two and for the channel count itself.
  localparam int BASE_W       = 8;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_SET_ONE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_GROUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EMIT      = 2'd2;

  typedef enum logic [1:0] {
    OP_SET_ONE,
    OP_SET_GROUP,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [CH_W-1:0]    ch;
    logic [LEVEL_W-1:0] lvl0;
    logic [LEVEL_W-1:0] lvl1;
    logic [LEVEL_W-1:0] lvl2;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage
`default_nettype wire

// ----- src/lgps_if.sv -----
`default_nettype none
interface lgps_in_if import lgps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [IDX_W-1:0]   index;
  logic [LEVEL_W-1:0] value;
  logic [LEVEL_W-1:0] red;
  logic [LEVEL_W-1:0] green;
  logic [LEVEL_W-1:0] blue;

  modport source(output valid, command, index, value, red, green, blue, input ready);
  modport sink(input valid, command, index, value, red, green, blue, output ready);
endinterface

interface lgps_out_if import lgps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;
  logic              last;

  modport source(output valid, stream_byte, last, input ready);
  modport sink(input valid, stream_byte, last, output ready);
endinterface
`default_nettype wire

// ----- src/lgps_front.sv -----
`default_nettype none
module lgps_front import lgps_pkg::*; (
  lgps_in_if.sink   in_ch,
  input  q_status_t q_status,
  output logic      q_push,
  output entry_t    q_entry
);

  logic [BASE_W-1:0] idx_ext;
  logic [BASE_W-1:0] base;
  logic              keep;

  assign idx_ext = {{(BASE_W-IDX_W){1'b0}}, in_ch.index};
  assign base    = (idx_ext << 1) + idx_ext;

  // Items that change nothing are taken and dropped here.
  always_comb begin
    q_entry.op   = OP_EMIT;
    q_entry.ch   = '0;
    q_entry.lvl0 = in_ch.value;
    q_entry.lvl1 = in_ch.blue;
    q_entry.lvl2 = in_ch.green;
    keep         = 1'b0;
    unique case (in_ch.command)
      CMD_SET_ONE: begin
        q_entry.op = OP_SET_ONE;
        q_entry.ch = CH_W'(idx_ext);
        keep       = (idx_ext < BASE_W'(CHANNELS));
      end
      CMD_SET_GROUP: begin
        q_entry.op   = OP_SET_GROUP;
        q_entry.ch   = CH_W'(base);
        q_entry.lvl0 = in_ch.red;
        keep         = ((base + BASE_W'(2)) < BASE_W'(CHANNELS));
      end
      CMD_EMIT: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = !q_status.full;
  assign q_push      = in_ch.valid && in_ch.ready && keep;

endmodule
`default_nettype wire

// ----- src/lgps_queue.sv -----
`default_nettype none
module lgps_queue import lgps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  entry_t    push_entry,
  input  logic      pop,
  output entry_t    head,
  output q_status_t status
);

  entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign head         = mem_r[rd_ptr_r];
  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/lgps_back.sv -----
`default_nettype none
module lgps_back import lgps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  entry_t    head,
  input  q_status_t q_status,
  output logic      q_pop,
  lgps_out_if.source out_ch
);

  typedef enum logic {
    BK_IDLE,
    BK_STREAM
  } bk_state_t;

  bk_state_t          state_r;
  logic [LEVEL_W-1:0] lvl_r [CHANNELS];
  logic [STREAM_W-1:0] sr_r;
  logic [STREAM_W-1:0] stream_w;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;
  logic [CH_W-1:0]    ch1;
  logic [CH_W-1:0]    ch2;

  assign q_pop = (state_r == BK_IDLE) && !q_status.empty;
  assign ch1   = head.ch + CH_W'(1);
  assign ch2   = head.ch + CH_W'(2);

  // Channel 0 sits at the bottom; pad bits at the top stay zero.
  always_comb begin
    stream_w = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      stream_w[i*LEVEL_W +: LEVEL_W] = lvl_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        lvl_r[i] <= '0;
      end
    end else if (q_pop) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (head.op == OP_SET_ONE && head.ch == CH_W'(i)) begin
          lvl_r[i] <= head.lvl0;
        end else if (head.op == OP_SET_GROUP) begin
          if (head.ch == CH_W'(i)) begin
            lvl_r[i] <= head.lvl0;
          end else if (ch1 == CH_W'(i)) begin
            lvl_r[i] <= head.lvl1;
          end else if (ch2 == CH_W'(i)) begin
            lvl_r[i] <= head.lvl2;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      unique case (state_r)
        BK_IDLE: begin
          if (q_pop && head.op == OP_EMIT) begin
            sr_r        <= stream_w;
            cnt_r       <= '0;
            out_valid_r <= 1'b1;
            state_r     <= BK_STREAM;
          end
        end
        BK_STREAM: begin
          if (out_ch.ready) begin
            if (out_ch.last) begin
              out_valid_r <= 1'b0;
              state_r     <= BK_IDLE;
            end else begin
              sr_r  <= {sr_r[STREAM_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
              cnt_r <= cnt_r + CNT_W'(1);
            end
          end
        end
        default: begin
          state_r <= BK_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.stream_byte = sr_r[STREAM_W-1 -: BYTE_W];
  assign out_ch.last        = (cnt_r == CNT_W'(STREAM_BYTES - 1));

endmodule
`default_nettype wire

// ----- src/led_grayscale_packer_shifter_core.sv -----
// Channel   Dir   Payload                                   Handshake
// in_ch     in    command, index, value, red, green, blue   valid / ready
// out_ch    out   stream_byte, last                         valid / ready
//
// A set item is applied in the back end as it is popped; an emit item loads the stream
// and then holds the back end until the serializer has taken all 24 bytes.
// The front takes one item per cycle as long as the two-entry queue has room.
// Reset (rst_n low, synchronous) clears all channel levels at once.
// A stalled output holds its byte; queued items then wait behind the stream.
`default_nettype none
`include "led_grayscale_packer_shifter_core_defines.svh"
module led_grayscale_packer_shifter_core import lgps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lgps_in_if.sink    in_ch,
  lgps_out_if.source out_ch
);

  // The front decodes items and drops those that change nothing.
  logic      q_push;
  logic      q_pop;
  entry_t    q_in;
  entry_t    q_head;
  q_status_t q_status;

  lgps_front u_front (
    .in_ch    (in_ch),
    .q_status (q_status),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  // The queue decouples the bus side from the stream side.
  lgps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  // The back end owns the channel levels and shifts out the stream.
  lgps_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .q_status (q_status),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

  // Nothing is pushed into a full queue.
  `LGPS_ASSERT_NOW(a_no_push_full, clk, rst_n, q_push, !q_status.full)
  // The back end never takes a new item while a stream is pending.
  `LGPS_ASSERT_NOW(a_no_pop_stream, clk, rst_n, out_ch.valid, !q_pop)
  // After the last byte is taken, the stream ends.
  `LGPS_ASSERT_NEXT(a_end_stream, clk, rst_n,
    out_ch.valid && out_ch.ready && out_ch.last, !out_ch.valid)

endmodule
`default_nettype wire

// ----- bench/tb_led_grayscale_packer_shifter_core.sv -----
`timescale 1ns / 100ps
module tb_led_grayscale_packer_shifter_core;
  import lgps_pkg::*;

  // Command code that the block leaves unused; it must change nothing and emit nothing.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Cycles with no accepted item on either channel before the run is declared hung.
  // The slowest legal gap is a full sender wait plus a full receiver stall
  // behind a queued emit and its load, so this leaves a wide margin.
  localparam int HANG_LIMIT = 1000;

  // Cycles to keep watching after the last expected byte. This is about two full
  // emit streams, so a stray byte from a late or duplicated emit would still be seen.
  localparam int DRAIN_CYCLES = 50;

  typedef struct {
    logic [CMD_W-1:0]   command;
    logic [IDX_W-1:0]   index;
    logic [LEVEL_W-1:0] value;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } cmd_item_t;

  typedef struct {
    logic [BYTE_W-1:0] stream_byte;
    logic              last;
  } stream_byte_t;

  // The scoreboard keeps its own copy of the channel levels. Every emit is turned
  // into the full byte stream at the moment the emit item is accepted.
  class grayscale_scoreboard;
    logic [LEVEL_W-1:0] levels [CHANNELS];
    stream_byte_t       pending_bytes [$];
    int                 mismatches;

    function new();
      foreach (levels[ch]) levels[ch] = '0;
      mismatches = 0;
    endfunction

    function void note_input(cmd_item_t it);
      int                  base;
      logic [STREAM_W-1:0] packed_bits;
      stream_byte_t        sb;
      base = int'(it.index) * 3;
      case (it.command)
        CMD_SET_ONE: begin
          if (int'(it.index) < CHANNELS) levels[it.index] = it.value;
        end
        CMD_SET_GROUP: begin
          // A group is written only when all three of its channels exist.
          if (base + 2 < CHANNELS) begin
            levels[base]     = it.red;
            levels[base + 1] = it.blue;
            levels[base + 2] = it.green;
          end
        end
        CMD_EMIT: begin
          // The highest channel lands in the top bits. Any padding sits above it
          // as zeros, so it goes out first.
          packed_bits = '0;
          for (int ch = 0; ch < CHANNELS; ch++)
            packed_bits[ch * LEVEL_W +: LEVEL_W] = levels[ch];
          for (int k = 0; k < STREAM_BYTES; k++) begin
            sb.stream_byte = packed_bits[STREAM_W - 1 - k * BYTE_W -: BYTE_W];
            sb.last        = (k == STREAM_BYTES - 1);
            pending_bytes.push_back(sb);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(logic [BYTE_W-1:0] got_byte, logic got_last);
      stream_byte_t exp_sb;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected stream byte %02h last %0b", got_byte, got_last);
      end else begin
        exp_sb = pending_bytes.pop_front();
        if (got_byte !== exp_sb.stream_byte || got_last !== exp_sb.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("stream byte mismatch: expected %02h last %0b, got %02h last %0b",
                     exp_sb.stream_byte, exp_sb.last, got_byte, got_last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lgps_in_if  in_ch ();
  lgps_out_if out_ch ();

  led_grayscale_packer_shifter_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  grayscale_scoreboard sb = new();

  // Largest wait, in cycles, that each side may draw before its next item. The
  // phases below change these values so that some stretches run with no idling at all.
  int in_gap_max  = 9;
  int out_stall_max = 9;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Reset is held once, at the start of the run. Every input of the block is given a
  // known value at time zero.
  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_SET_ONE;
    in_ch.index    <= '0;
    in_ch.value    <= '0;
    in_ch.red      <= '0;
    in_ch.green    <= '0;
    in_ch.blue     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Every value is sampled right after the rising edge. At that point the values
  // are still the ones the block saw at that edge, because all updates are
  // nonblocking. Accepted input items go into the prediction, and accepted result
  // items are checked against it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_input('{in_ch.command, in_ch.index, in_ch.value,
                        in_ch.red, in_ch.green, in_ch.blue});
      end
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.stream_byte, out_ch.last);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Hang detection: the run stops once nothing has moved on either channel for too long.
  initial begin
    while (idle_cycles < HANG_LIMIT) @(posedge clk);
    $display("led_grayscale_packer_shifter_core regression: fail");
    $finish;
  end

  // The serializer side draws a stall of its own before each byte it takes.
  // Ready gets its first value at time zero from the first draw.
  initial begin : serializer
    int stall;
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Presents one item after a random wait and returns at the edge where it is taken.
  // When the wait is zero, valid stays high from the previous item. This way valid is
  // never dropped and raised again in the same step.
  task automatic send_item(input cmd_item_t it);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= it.command;
    in_ch.index   <= it.index;
    in_ch.value   <= it.value;
    in_ch.red     <= it.red;
    in_ch.green   <= it.green;
    in_ch.blue    <= it.blue;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic send(input logic [CMD_W-1:0] command, input int index,
                      input int value, input int red, input int green, input int blue);
    send_item('{command, IDX_W'(index), LEVEL_W'(value), LEVEL_W'(red),
                LEVEL_W'(green), LEVEL_W'(blue)});
  endtask

  // Levels lean toward the two extremes so that full-scale and dark channels come up often.
  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  // Random traffic looks like normal use: mostly channel and group writes, with an emit
  // now and then. Most group numbers are valid ones. A few are out-of-range groups or
  // unused commands, and those must leave the levels untouched.
  function automatic cmd_item_t random_item();
    cmd_item_t it;
    int        pick;
    pick     = $urandom_range(0, 99);
    it.index = IDX_W'($urandom);
    it.value = pick_level();
    it.red   = pick_level();
    it.green = pick_level();
    it.blue  = pick_level();
    if (pick < 40) begin
      it.command = CMD_SET_ONE;
    end else if (pick < 75) begin
      it.command = CMD_SET_GROUP;
      if ($urandom_range(0, 4) != 0) it.index = IDX_W'($urandom_range(0, CHANNELS / 3 - 1));
    end else if (pick < 95) begin
      it.command = CMD_EMIT;
    end else begin
      it.command = CMD_UNUSED;
    end
    return it;
  endfunction

  initial begin : stimulus
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Directed part. First, the stream straight after reset must be all zeros.
    send(CMD_EMIT, 0, 0, 0, 0, 0);
    // Full scale on the first and last channel, plus a mixed pattern in the middle.
    send(CMD_SET_ONE, 0, 4095, 0, 0, 0);
    send(CMD_SET_ONE, 15, 4095, 0, 0, 0);
    send(CMD_SET_ONE, 8, 'hA5A, 0, 0, 0);
    send(CMD_EMIT, 0, 0, 0, 0, 0);
    // Group writes at the lowest and highest complete group check the red, blue, green order.
    send(CMD_SET_GROUP, 0, 0, 4095, 0, 'h800);
    send(CMD_SET_GROUP, 4, 0, 'h001, 4095, 'h7FF);
    // Incomplete groups and the unused command must not disturb any level.
    send(CMD_SET_GROUP, 5, 4095, 4095, 4095, 4095);
    send(CMD_SET_GROUP, 15, 4095, 4095, 4095, 4095);
    send(CMD_UNUSED, 3, 4095, 4095, 4095, 4095);
    send(CMD_EMIT, 0, 0, 0, 0, 0);
    send(CMD_SET_ONE, 15, 0, 0, 0, 0);
    send(CMD_SET_ONE, 0, 0, 0, 0, 0);
    send(CMD_EMIT, 0, 0, 0, 0, 0);

    // Random part in four phases. Each phase uses its own idling mix, so pauses fall
    // on every point of a stream and some phases run back to back.
    for (int phase = 0; phase < 4; phase++) begin
      in_gap_max  = (phase == 0 || phase == 3) ? 9 : 0;
      out_stall_max = (phase == 0 || phase == 2) ? 9 : 0;
      for (int n = 0; n < 25; n++) send_item(random_item());
    end
    in_ch.valid <= 1'b0;

    // Wait until every expected byte has come, then keep watching for stray bytes.
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_bytes.size() == 0)
      $display("led_grayscale_packer_shifter_core regression: pass");
    else
      $display("led_grayscale_packer_shifter_core regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/lgps_pkg.sv
src/lgps_if.sv
src/lgps_front.sv
src/lgps_queue.sv
src/lgps_back.sv
src/led_grayscale_packer_shifter_core.sv
bench/tb_led_grayscale_packer_shifter_core.sv
